// ===== design/mpeg_audio_frame_header_decode_defines.svh =====
// Assertion macros for the frame header decoder top level
`ifndef MPEG_AUDIO_FRAME_HEADER_DECODE_DEFINES_SVH
`define MPEG_AUDIO_FRAME_HEADER_DECODE_DEFINES_SVH

// Plain property, sampled on the rising clock and off while reset is low
`define MAFHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Overlapping implication built on the plain form
`define MAFHD_ASSERT_IMPL(lbl, ante, cons, msg) \
  `MAFHD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/mafhd_pkg.sv =====
// Types, constants and lookup functions for the frame header decoder
package mafhd_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned KBPS_W      = 9;
  localparam int unsigned RATE_W      = 16;
  localparam int unsigned SPF_W       = 11;
  localparam int unsigned BYTES_W     = 11;
  localparam int unsigned COEF_W      = 19;
  localparam int unsigned PROD_W      = KBPS_W + COEF_W;
  localparam int unsigned NUM_W       = 26;
  localparam int unsigned RECIP_W     = 26;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned QPROD_W     = NUM_W + RECIP_W;
  localparam int unsigned REM_W       = BYTES_W + RATE_W;

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] SYNC_MASK_HI = 8'hF0;
  localparam logic [7:0] SYNC_MASK_25 = 8'hFE;
  localparam logic [7:0] SYNC_CODE_25 = 8'hE2;

  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  localparam logic [1:0] LAYER_RSVD = 2'd0;
  localparam logic [1:0] LAYER_III  = 2'd1;
  localparam logic [1:0] LAYER_II   = 2'd2;
  localparam logic [1:0] LAYER_I    = 2'd3;

  localparam logic [3:0] BRX_FREE = 4'd0;
  localparam logic [3:0] BRX_BAD  = 4'd15;
  localparam logic [1:0] FRX_RSVD = 2'd3;
  localparam logic [1:0] MODE_DUAL = 2'd2;
  localparam logic [1:0] MODE_MONO = 2'd3;

  localparam logic [SPF_W-1:0] SPF_L1   = 11'd384;
  localparam logic [SPF_W-1:0] SPF_FULL = 11'd1152;
  localparam logic [SPF_W-1:0] SPF_HALF = 11'd576;
  localparam logic [COEF_W-1:0] BYTE_SCALE = 19'd125;

  localparam logic [KBPS_W-1:0] KBPS_TAB [2][3][16] = '{
    '{
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
    }
  };

  typedef struct packed {
    logic               hdr_ok;
    logic               mono;
    logic               free;
    logic [KBPS_W-1:0]  kbps;
    logic [RATE_W-1:0]  rate;
    logic [SPF_W-1:0]   spf;
    logic [COEF_W-1:0]  coef;
    logic               size_en;
    logic               layer_i;
    logic               pad;
    logic [1:0]         frx;
  } hdr_info_t;

  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic mp1,
                                                    input logic [1:0] layer,
                                                    input logic [3:0] brx);
    logic [1:0] row;
    unique case (layer)
      LAYER_III: row = 2'd0;
      LAYER_II:  row = 2'd1;
      default:   row = 2'd2;
    endcase
    return KBPS_TAB[mp1][row][brx];
  endfunction

  function automatic logic [RATE_W-1:0] base_rate(input logic [1:0] frx);
    logic [RATE_W-1:0] r;
    unique case (frx)
      2'd0:    r = 16'd44100;
      2'd1:    r = 16'd48000;
      2'd2:    r = 16'd32000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // floor(2^40 / base rate)
  function automatic logic [RECIP_W-1:0] base_recip(input logic [1:0] frx);
    logic [RECIP_W-1:0] m;
    unique case (frx)
      2'd0:    m = 26'd24932236;
      2'd1:    m = 26'd22906492;
      2'd2:    m = 26'd34359738;
      default: m = 26'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== design/mafhd_field_decode.sv =====
// Field split, validity check and table lookups, first pipeline stage
module mafhd_field_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [mafhd_pkg::WORD_W-1:0]      header_word_i,
  output logic                              out_valid_o,
  output mafhd_pkg::hdr_info_t              info_o
);
  import mafhd_pkg::*;

  logic [7:0]        b0;
  logic [7:0]        b1;
  logic [1:0]        ver;
  logic [1:0]        layer;
  logic [3:0]        brx;
  logic [1:0]        frx;
  logic              pad;
  logic [1:0]        mode;
  logic              sync;
  logic              ok;
  logic [1:0]        shift;
  logic [SPF_W-1:0]  spf;
  logic [COEF_W-1:0] coef_base;
  hdr_info_t         info_d;
  hdr_info_t         info_q;
  logic              valid_q;

  assign b0    = header_word_i[31:24];
  assign b1    = header_word_i[23:16];
  assign ver   = b1[4:3];
  assign layer = b1[2:1];
  assign brx   = header_word_i[15:12];
  assign frx   = header_word_i[11:10];
  assign pad   = header_word_i[9];
  assign mode  = header_word_i[7:6];

  assign sync = (b0 == SYNC_BYTE) &&
                (((b1 & SYNC_MASK_HI) == SYNC_MASK_HI) ||
                 ((b1 & SYNC_MASK_25) == SYNC_CODE_25));
  assign ok   = sync && (layer != LAYER_RSVD) && (brx != BRX_BAD) &&
                (frx != FRX_RSVD) && (mode != MODE_DUAL);

  always_comb begin
    unique case (ver)
      VER_MPEG25: shift = 2'd2;
      VER_MPEG2:  shift = 2'd1;
      default:    shift = 2'd0;
    endcase
  end

  always_comb begin
    if (layer == LAYER_I) begin
      spf = SPF_L1;
    end else if ((layer == LAYER_II) || (ver == VER_MPEG1)) begin
      spf = SPF_FULL;
    end else begin
      spf = SPF_HALF;
    end
  end

  assign coef_base = COEF_W'(spf) * BYTE_SCALE;

  always_comb begin
    info_d = '0;
    if (ok) begin
      info_d.hdr_ok  = 1'b1;
      info_d.mono    = (mode == MODE_MONO);
      info_d.free    = (brx == BRX_FREE);
      info_d.kbps    = kbps_lookup(ver == VER_MPEG1, layer, brx);
      info_d.rate    = base_rate(frx) >> shift;
      info_d.spf     = spf;
      info_d.coef    = coef_base << shift;
      info_d.size_en = (brx != BRX_FREE);
      info_d.layer_i = (layer == LAYER_I);
      info_d.pad     = pad;
      info_d.frx     = frx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    info_q <= info_d;
  end

  assign out_valid_o = valid_q;
  assign info_o      = info_q;

endmodule

// ===== design/mafhd_frame_size.sv =====
// Frame size by reciprocal multiply and remainder correction, three stages
module mafhd_frame_size (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  mafhd_pkg::hdr_info_t              info_i,
  output logic                              out_valid_o,
  output mafhd_pkg::hdr_info_t              info_o,
  output logic [mafhd_pkg::BYTES_W-1:0]     frame_bytes_o
);
  import mafhd_pkg::*;

  logic [PROD_W-1:0]  num_full;
  logic [NUM_W-1:0]   num2_d;
  logic [NUM_W-1:0]   num2_q;
  hdr_info_t          info2_q;
  logic               v2_q;

  logic [QPROD_W-1:0] qprod;
  logic [BYTES_W-1:0] q0_d;
  logic [BYTES_W-1:0] q0_q;
  logic [NUM_W-1:0]   num3_q;
  hdr_info_t          info3_q;
  logic               v3_q;

  logic [RATE_W-1:0]  base;
  logic [REM_W-1:0]   qd;
  logic [REM_W-1:0]   rem;
  logic [BYTES_W-1:0] q;
  logic [BYTES_W-1:0] bytes_d;
  logic [BYTES_W-1:0] bytes_q;
  hdr_info_t          info4_q;
  logic               v4_q;

  assign num_full = PROD_W'(info_i.kbps) * PROD_W'(info_i.coef);
  assign num2_d   = num_full[NUM_W-1:0];

  assign qprod = QPROD_W'(num2_q) * QPROD_W'(base_recip(info2_q.frx));
  assign q0_d  = qprod[RECIP_SHIFT +: BYTES_W];

  assign base = base_rate(info3_q.frx);
  assign qd   = REM_W'(q0_q) * REM_W'(base);
  assign rem  = REM_W'(num3_q) - qd;
  assign q    = (rem >= REM_W'(base)) ? (q0_q + BYTES_W'(1)) : q0_q;

  always_comb begin
    if (!info3_q.size_en) begin
      bytes_d = '0;
    end else if (info3_q.layer_i) begin
      bytes_d = {q[BYTES_W-1:2], 2'b00} + (info3_q.pad ? BYTES_W'(4) : BYTES_W'(0));
    end else begin
      bytes_d = q + BYTES_W'(info3_q.pad);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= in_valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num2_q  <= num2_d;
    info2_q <= info_i;
    q0_q    <= q0_d;
    num3_q  <= num2_q;
    info3_q <= info2_q;
    bytes_q <= bytes_d;
    info4_q <= info3_q;
  end

  assign out_valid_o   = v4_q;
  assign info_o        = info4_q;
  assign frame_bytes_o = bytes_q;

endmodule

// ===== design/mpeg_audio_frame_header_decode.sv =====
// Top level of the MPEG audio frame header decoder
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   command  | start, busy            | header_word_i
//   result   | result_valid_o strobe  | header_valid_o is_mono_o free_format_o
//            |                        | bitrate_kbps_o sample_rate_o
//            |                        | samples_per_frame_o frame_bytes_o
//
// One item enters per cycle; busy stays low.
// Each result passes through the four pipeline stages:
// field decode, numerator multiply, reciprocal multiply, remainder correction.
// Reset clears the stage valid bits only; payload registers are left as they are.
// The result strobe lasts one cycle and is never held back.
`include "mpeg_audio_frame_header_decode_defines.svh"

module mpeg_audio_frame_header_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [mafhd_pkg::WORD_W-1:0]      header_word_i,
  output logic                              result_valid_o,
  output logic                              header_valid_o,
  output logic                              is_mono_o,
  output logic                              free_format_o,
  output logic [mafhd_pkg::KBPS_W-1:0]      bitrate_kbps_o,
  output logic [mafhd_pkg::RATE_W-1:0]      sample_rate_o,
  output logic [mafhd_pkg::SPF_W-1:0]       samples_per_frame_o,
  output logic [mafhd_pkg::BYTES_W-1:0]     frame_bytes_o
);
  import mafhd_pkg::*;

  logic      accept;
  logic      dec_valid;
  hdr_info_t dec_info;
  hdr_info_t res_info;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mafhd_field_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (accept),
    .header_word_i (header_word_i),
    .out_valid_o   (dec_valid),
    .info_o        (dec_info)
  );

  mafhd_frame_size u_size (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (dec_valid),
    .info_i        (dec_info),
    .out_valid_o   (result_valid_o),
    .info_o        (res_info),
    .frame_bytes_o (frame_bytes_o)
  );

  assign header_valid_o      = res_info.hdr_ok;
  assign is_mono_o           = res_info.mono;
  assign free_format_o       = res_info.free;
  assign bitrate_kbps_o      = res_info.kbps;
  assign sample_rate_o       = res_info.rate;
  assign samples_per_frame_o = res_info.spf;

  `MAFHD_ASSERT_IMPL(a_latency, start && !busy, ##4 result_valid_o, "item lost in pipeline")
  `MAFHD_ASSERT_IMPL(a_origin, result_valid_o, $past(start && !busy, 4), "result without item")
  `MAFHD_ASSERT_IMPL(a_bad_zero, result_valid_o && !header_valid_o,
    !is_mono_o && !free_format_o && bitrate_kbps_o == '0 && sample_rate_o == '0 &&
    samples_per_frame_o == '0 && frame_bytes_o == '0, "rejected header not zeroed")
  `MAFHD_ASSERT_IMPL(a_free_size, result_valid_o && free_format_o,
    header_valid_o && bitrate_kbps_o == '0 && frame_bytes_o == '0, "free format sized")

endmodule
